FILE: hdl/bqg_pkg.sv
// shared types and constants for the biquad with gain and bypass
// no dependencies; imported by every module of the block

package bqg_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CHAN_W     = 3;
    localparam int COEF_W     = 32;
    localparam int GAIN_W     = 23;
    localparam int DELAY_W    = 40;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // serial-parallel multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // register indexes
    localparam logic [2:0] REG_B0     = 3'd0;
    localparam logic [2:0] REG_B1     = 3'd1;
    localparam logic [2:0] REG_B2     = 3'd2;
    localparam logic [2:0] REG_A1     = 3'd3;
    localparam logic [2:0] REG_A2     = 3'd4;
    localparam logic [2:0] REG_GAIN_I = 3'd5;
    localparam logic [2:0] REG_GAIN_O = 3'd6;
    localparam logic [2:0] REG_BYPASS = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAUNCH,
        S_WAIT,
        S_ACC,
        S_OUT
    } seq_state_t;

    // the seven products in the order they are computed
    typedef enum logic [2:0] {
        P_XG,
        P_B0,
        P_B1,
        P_A1,
        P_B2,
        P_A2,
        P_GO
    } prod_step_t;

    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

FILE: hdl/biquad_df2t_gain_bypass.sv
// top level: per-channel transposed direct form II biquad with gains and bypass
// depends on bqg_pkg, bqg_mul, bqg_dly_mem
//
//  port group   direction  contents (lowest bit up)
//  s_*          in         tuser: channel[2:0]; tdata: sample_in[23:0]
//  m_*          out        tuser: channel_out[2:0]; tdata: sample_out[23:0]
//  apb          in/out     eight 32-bit registers at 4*index, pready always high
//
//  each item runs a delay read, then seven products through one radix-2
//  serial multiplier (launch, bit steps, round, accumulate), then the output;
//  no new request is taken until the last result is in the output register
//  reset clears the sequencer, the output valid and the delay valid bits, so
//  every channel starts with zero delay words
//  the result sits in an output register; the next request is taken while it
//  waits, and the block only stalls if a new result is ready before the old
//  one has been taken

module biquad_df2t_gain_bypass import bqg_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // sample_in[23:0]
    input  logic [CHAN_W-1:0]     s_tuser,   // channel[2:0]
    // result requests
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata,   // sample_out[23:0]
    output logic [CHAN_W-1:0]     m_tuser    // channel_out[2:0]
);

    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------------------------------------------------------- registers
    logic signed [COEF_W-1:0] b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [GAIN_W-1:0]        gin_reg, gout_reg;
    logic                     byp_reg;
    logic                     cfg_wr;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_reg   <= 32'sh1000_0000;  // 1.0 in q4.28
            b1_reg   <= '0;
            b2_reg   <= '0;
            a1_reg   <= '0;
            a2_reg   <= '0;
            gin_reg  <= 23'h01_0000;     // 1.0 in q7.16
            gout_reg <= 23'h01_0000;
            byp_reg  <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_B0:     b0_reg   <= pwdata;
                REG_B1:     b1_reg   <= pwdata;
                REG_B2:     b2_reg   <= pwdata;
                REG_A1:     a1_reg   <= pwdata;
                REG_A2:     a2_reg   <= pwdata;
                REG_GAIN_I: gin_reg  <= pwdata[GAIN_W-1:0];
                REG_GAIN_O: gout_reg <= pwdata[GAIN_W-1:0];
                REG_BYPASS: byp_reg  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_B0:     prdata = b0_reg;
            REG_B1:     prdata = b1_reg;
            REG_B2:     prdata = b2_reg;
            REG_A1:     prdata = a1_reg;
            REG_A2:     prdata = a2_reg;
            REG_GAIN_I: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gin_reg};
            REG_GAIN_O: prdata = {{(APB_DATA_W-GAIN_W){1'b0}}, gout_reg};
            REG_BYPASS: prdata = {{(APB_DATA_W-1){1'b0}}, byp_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- saturation
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v[43:31] == {13{v[31]}}) begin
            return v[31:0];
        end
        return v[43] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

    function automatic logic signed [DELAY_W-1:0] sat40(input logic signed [43:0] v);
        if (v[43:39] == {5{v[39]}}) begin
            return v[DELAY_W-1:0];
        end
        return v[43] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [49:0] v);
        if (v[49:23] == {27{v[23]}}) begin
            return v[SAMPLE_W-1:0];
        end
        return v[49] ? 24'sh80_0000 : 24'sh7f_ffff;
    endfunction

    // ---------------------------------------------------------------- datapath state
    seq_state_t state_reg, state_next;
    prod_step_t step_reg, step_next;

    logic [CHAN_W-1:0]          ch_reg, ch_next;
    logic signed [SAMPLE_W-1:0] raw_reg, raw_next;
    logic                       ok_reg, ok_next;
    logic signed [DELAY_W-1:0]  d1_reg, d1_next;
    logic signed [DELAY_W-1:0]  d2_reg, d2_next;
    logic signed [31:0]         x_reg, x_next;
    logic signed [31:0]         y_reg, y_next;
    logic signed [43:0]         acc_reg, acc_next;
    logic signed [DELAY_W-1:0]  n1_reg, n1_next;
    logic signed [DELAY_W-1:0]  n2_reg, n2_next;
    logic signed [49:0]         rnd_reg, rnd_next;
    logic signed [SAMPLE_W-1:0] res_reg, res_next;

    logic                       m_valid_reg, m_valid_next;
    logic [CHAN_W-1:0]          m_ch_reg, m_ch_next;
    logic signed [SAMPLE_W-1:0] m_smp_reg, m_smp_next;

    // multiplier and memory hookup
    logic                      mul_start;
    logic                      mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_prod;

    mem_cmd_t           mem_cmd;
    logic [ADDR_W-1:0]  mem_addr;
    logic [DELAY_W-1:0] mem_one;
    logic [DELAY_W-1:0] mem_two;

    logic ch_ok;
    logic out_load;

    assign ch_ok    = (32'(s_tuser) < CHANNELS);
    assign s_tready = (state_reg == S_IDLE);
    // read address comes from the bus, write address from the held channel
    assign mem_addr = (state_reg == S_IDLE) ? ADDR_W'(s_tuser) : ADDR_W'(ch_reg);

    // operand select for the product of the current step
    always_comb begin
        case (step_reg)
            P_XG: begin
                mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, gin_reg};
                mul_b = {{(MUL_B_W-SAMPLE_W){raw_reg[SAMPLE_W-1]}}, raw_reg};
            end
            P_B0: begin
                mul_a = {{2{b0_reg[COEF_W-1]}}, b0_reg};
                mul_b = x_reg;
            end
            P_B1: begin
                mul_a = {{2{b1_reg[COEF_W-1]}}, b1_reg};
                mul_b = x_reg;
            end
            P_A1: begin
                // feedback coefficients enter negated
                mul_a = -$signed({{2{a1_reg[COEF_W-1]}}, a1_reg});
                mul_b = y_reg;
            end
            P_B2: begin
                mul_a = {{2{b2_reg[COEF_W-1]}}, b2_reg};
                mul_b = x_reg;
            end
            P_A2: begin
                mul_a = -$signed({{2{a2_reg[COEF_W-1]}}, a2_reg});
                mul_b = y_reg;
            end
            P_GO: begin
                mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, gout_reg};
                mul_b = y_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer and arithmetic between products
    always_comb begin
        logic               shift16;
        logic signed [PROD_W-1:0] rsum;
        logic signed [43:0] rnd44;
        logic signed [43:0] d1_ext;
        logic signed [43:0] d2_ext;

        shift16 = (step_reg == P_XG) || (step_reg == P_GO);
        // round half up: add half an output lsb, then drop the fraction
        rsum    = mul_prod + (shift16 ? PROD_W'(1 << 15) : PROD_W'(1 << 27));
        rnd44   = rnd_reg[43:0];
        d1_ext  = {{4{d1_reg[DELAY_W-1]}}, d1_reg};
        d2_ext  = {{4{d2_reg[DELAY_W-1]}}, d2_reg};

        state_next = state_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        raw_next   = raw_reg;
        ok_next    = ok_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        n1_next    = n1_reg;
        n2_next    = n2_reg;
        rnd_next   = rnd_reg;
        res_next   = res_reg;
        mul_start  = 1'b0;
        mem_cmd    = '0;
        out_load   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ch_next    = s_tuser;
                    raw_next   = s_tdata;
                    ok_next    = ch_ok;
                    mem_cmd.rd = ch_ok;
                    step_next  = P_XG;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // channel out of range filters from zero state
                d1_next    = ok_reg ? mem_one : '0;
                d2_next    = ok_reg ? mem_two : '0;
                state_next = S_LAUNCH;
            end
            S_LAUNCH: begin
                mul_start  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (mul_done) begin
                    if (shift16) begin
                        rnd_next = rsum[PROD_W-1:16];
                    end else begin
                        rnd_next = {{12{rsum[PROD_W-1]}}, rsum[PROD_W-1:28]};
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                state_next = S_LAUNCH;
                case (step_reg)
                    P_XG: begin
                        x_next    = rnd_reg[31:0];
                        step_next = P_B0;
                    end
                    P_B0: begin
                        y_next    = sat32(rnd44 + d1_ext);
                        step_next = P_B1;
                    end
                    P_B1: begin
                        acc_next  = rnd44 + d2_ext;
                        step_next = P_A1;
                    end
                    P_A1: begin
                        n1_next   = sat40(acc_reg + rnd44);
                        step_next = P_B2;
                    end
                    P_B2: begin
                        acc_next  = rnd44;
                        step_next = P_A2;
                    end
                    P_A2: begin
                        n2_next   = sat40(acc_reg + rnd44);
                        step_next = P_GO;
                    end
                    P_GO: begin
                        res_next   = byp_reg ? raw_reg : sat24(rnd_reg);
                        state_next = S_OUT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OUT: begin
                // hand over once the output register is free, and store state at the same time
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    mem_cmd.wr = ok_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
            m_ch_next    = ch_reg;
            m_smp_next   = res_reg;
        end else begin
            m_valid_next = m_tready ? 1'b0 : m_valid_reg;
            m_ch_next    = m_ch_reg;
            m_smp_next   = m_smp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= P_XG;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg    <= ch_next;
        raw_reg   <= raw_next;
        ok_reg    <= ok_next;
        d1_reg    <= d1_next;
        d2_reg    <= d2_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        acc_reg   <= acc_next;
        n1_reg    <= n1_next;
        n2_reg    <= n2_next;
        rnd_reg   <= rnd_next;
        res_reg   <= res_next;
        m_ch_reg  <= m_ch_next;
        m_smp_reg <= m_smp_next;
    end

    // ---------------------------------------------------------------- submodules
    bqg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    bqg_dly_mem #(
        .CHANNELS (CHANNELS)
    ) u_dly_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mem_cmd),
        .addr    (mem_addr),
        .wr_one  (n1_reg),
        .wr_two  (n2_reg),
        .rd_one  (mem_one),
        .rd_two  (mem_two)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_smp_reg;
    assign m_tuser  = m_ch_reg;

endmodule

FILE: hdl/bqg_mul.sv
// radix-2 serial-parallel signed multiplier, one multiplier bit per cycle
// depends on bqg_pkg

module bqg_mul import bqg_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                      done,
    output logic signed [PROD_W-1:0]  prod
);

    localparam int CNT_W = $clog2(MUL_B_W);

    logic signed [MUL_A_W-1:0] mcand_reg, mcand_next;
    logic signed [MUL_A_W:0]   hi_reg, hi_next;
    logic [MUL_B_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic signed [MUL_A_W:0] a_ext;
    logic signed [MUL_A_W:0] addend;
    logic signed [MUL_A_W:0] sum;
    logic                    last;

    always_comb begin
        a_ext = {mcand_reg[MUL_A_W-1], mcand_reg};
        last  = (cnt_reg == CNT_W'(MUL_B_W - 1));
        // sign bit of the multiplier has negative weight
        if (lo_reg[0]) begin
            addend = last ? -a_ext : a_ext;
        end else begin
            addend = '0;
        end
        sum = hi_reg + addend;

        mcand_next = mcand_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;

        if (start) begin
            mcand_next = a;
            hi_next    = '0;
            lo_next    = b;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            hi_next  = {sum[MUL_A_W], sum[MUL_A_W:1]};
            lo_next  = {sum[0], lo_reg[MUL_B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (last) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg <= mcand_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign done = done_reg;
    assign prod = {hi_reg[MUL_A_W-1:0], lo_reg};

endmodule

FILE: hdl/bqg_dly_mem.sv
// per-channel delay word memory, one port, registered read, valid bit per entry
// depends on bqg_pkg

module bqg_dly_mem import bqg_pkg::*; #(
    parameter int CHANNELS = 8,
    localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mem_cmd_t           cmd,
    input  logic [ADDR_W-1:0]  addr,
    input  logic [DELAY_W-1:0] wr_one,
    input  logic [DELAY_W-1:0] wr_two,
    output logic [DELAY_W-1:0] rd_one,
    output logic [DELAY_W-1:0] rd_two
);

    logic [DELAY_W-1:0] one_mem [CHANNELS];
    logic [DELAY_W-1:0] two_mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;

    logic [DELAY_W-1:0] one_q_reg;
    logic [DELAY_W-1:0] two_q_reg;
    logic               vld_q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            one_mem[addr] <= wr_one;
            two_mem[addr] <= wr_two;
        end
        if (cmd.rd) begin
            one_q_reg <= one_mem[addr];
            two_q_reg <= two_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end else begin
            if (cmd.wr) begin
                valid_reg[addr] <= 1'b1;
            end
            if (cmd.rd) begin
                vld_q_reg <= valid_reg[addr];
            end
        end
    end

    // never-written entries read as zero
    assign rd_one = vld_q_reg ? one_q_reg : '0;
    assign rd_two = vld_q_reg ? two_q_reg : '0;

endmodule

FILE: verif/biquad_result_checker.sv
// result checker for biquad_df2t_gain_bypass: follows register writes, predicts every result
// from accepted requests and compares it field by field; register reads are checked too
// depends on bqg_pkg
`timescale 1ns / 100ps

module biquad_result_checker import bqg_pkg::*; #(
    parameter int CHANNELS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // sample_in[23:0]
    input  logic [CHAN_W-1:0]     s_tuser,   // channel[2:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [SAMPLE_W-1:0]   m_tdata,   // sample_out[23:0]
    input  logic [CHAN_W-1:0]     m_tuser,   // channel_out[2:0]
    output int                    fail_count,
    output int                    pending_results
);

    typedef struct {
        logic [CHAN_W-1:0]   chan;
        logic [SAMPLE_W-1:0] smp;
    } out_sample_t;

    out_sample_t expected_samples[$];

    logic signed [COEF_W-1:0]  b0, b1, b2, a1, a2;
    logic        [GAIN_W-1:0]  gain_in, gain_out;
    logic                      bypass_on;
    logic signed [DELAY_W-1:0] dly_one [CHANNELS];
    logic signed [DELAY_W-1:0] dly_two [CHANNELS];

    initial begin
        fail_count      = 0;
        pending_results = 0;
    end

    task automatic note_mismatch(input string msg);
        fail_count++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // add half, then floor
    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one sample through the channel's filter; updates that channel's delay words
    function automatic logic [SAMPLE_W-1:0] step_filter(input logic [CHAN_W-1:0] ch,
                                                        input logic signed [SAMPLE_W-1:0] raw);
        longint d1, d2, x, y, n1, n2, res;
        logic   in_range;
        in_range = (int'(ch) < CHANNELS);
        d1 = in_range ? longint'(dly_one[ch]) : 0;
        d2 = in_range ? longint'(dly_two[ch]) : 0;

        x  = round_half_up(longint'(raw) * longint'(gain_in), 16);
        y  = clip_to(round_half_up(longint'(b0) * x, 28) + d1, 32);
        n1 = clip_to(round_half_up(longint'(b1) * x, 28) + d2
                     + round_half_up(-longint'(a1) * y, 28), DELAY_W);
        n2 = clip_to(round_half_up(longint'(b2) * x, 28)
                     + round_half_up(-longint'(a2) * y, 28), DELAY_W);

        if (in_range) begin
            dly_one[ch] = n1[DELAY_W-1:0];
            dly_two[ch] = n2[DELAY_W-1:0];
        end

        res = bypass_on ? longint'(raw) : clip_to(round_half_up(y * longint'(gain_out), 16),
                                                  SAMPLE_W);
        return res[SAMPLE_W-1:0];
    endfunction

    function automatic logic [APB_DATA_W-1:0] reg_readback(input logic [2:0] idx);
        case (idx)
            REG_B0:     return b0;
            REG_B1:     return b1;
            REG_B2:     return b2;
            REG_A1:     return a1;
            REG_A2:     return a2;
            REG_GAIN_I: return APB_DATA_W'(gain_in);
            REG_GAIN_O: return APB_DATA_W'(gain_out);
            default:    return APB_DATA_W'(bypass_on);
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        out_sample_t      oldest;
        logic [2:0]       idx;
        logic [APB_DATA_W-1:0] want;
        idx = paddr[APB_ADDR_W-1:2];
        if (!aresetn) begin
            expected_samples.delete();
            b0        = 32'h1000_0000;
            b1        = '0;
            b2        = '0;
            a1        = '0;
            a2        = '0;
            gain_in   = GAIN_W'(32'h1_0000);
            gain_out  = GAIN_W'(32'h1_0000);
            bypass_on = 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                dly_one[i] = '0;
                dly_two[i] = '0;
            end
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (idx)
                        REG_B0:     b0        = pwdata;
                        REG_B1:     b1        = pwdata;
                        REG_B2:     b2        = pwdata;
                        REG_A1:     a1        = pwdata;
                        REG_A2:     a2        = pwdata;
                        REG_GAIN_I: gain_in   = pwdata[GAIN_W-1:0];
                        REG_GAIN_O: gain_out  = pwdata[GAIN_W-1:0];
                        REG_BYPASS: bypass_on = pwdata[0];
                        default: ;
                    endcase
                end else begin
                    want = reg_readback(idx);
                    if (prdata !== want)
                        note_mismatch($sformatf("register %0d reads %h, expected %h",
                                                idx, prdata, want));
                end
            end

            if (s_tvalid && s_tready)
                expected_samples.push_back('{chan: s_tuser, smp: step_filter(s_tuser, s_tdata)});

            if (m_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    note_mismatch($sformatf("result ch %0d data %h with no request pending",
                                            m_tuser, m_tdata));
                end else begin
                    oldest = expected_samples.pop_front();
                    if (m_tuser !== oldest.chan)
                        note_mismatch($sformatf("channel_out %0d, expected %0d",
                                                m_tuser, oldest.chan));
                    if (m_tdata !== oldest.smp)
                        note_mismatch($sformatf("sample_out %h, expected %h (ch %0d)",
                                                m_tdata, oldest.smp, oldest.chan));
                end
            end
        end
        pending_results <= expected_samples.size();
    end

endmodule

FILE: verif/biquad_df2t_gain_bypass_tb.sv
// testbench top for biquad_df2t_gain_bypass: clock, reset, register programming and request
// traffic with random idling; prediction and comparison live in biquad_result_checker
// depends on bqg_pkg, biquad_result_checker and the block's rtl
`timescale 1ns / 100ps

module biquad_df2t_gain_bypass_tb import bqg_pkg::*; ();

    // about 900 requests: the limit leaves a wide margin
    localparam int CYCLE_LIMIT = 1_000_000;
    // long enough for the output register and the sequencer to fill up
    localparam int HOLD_CYCLES = 1500;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 70;

    typedef enum int {
        SET_MILD,   // coefficients within +-1.0 (a1 +-2.0), mostly well behaved
        SET_WILD,   // anything in the 32-bit range
        SET_EXTREME // every coefficient at min, max or zero
    } setting_kind_t;

    typedef struct packed {
        logic [COEF_W-1:0] b0, b1, b2, a1, a2;
        logic [GAIN_W-1:0] gin, gout;
        logic              byp;
    } filter_setting_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;   // sample_in[23:0]
    logic [CHAN_W-1:0]     s_tuser   = '0;   // channel[2:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;          // sample_out[23:0]
    logic [CHAN_W-1:0]     m_tuser;          // channel_out[2:0]

    int fail_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    logic [CHAN_W-1:0] last_chan = '0;

    biquad_df2t_gain_bypass #(.CHANNELS(8)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    biquad_result_checker #(.CHANNELS(8)) u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random back-pressure, plus a long hold-off whenever one is asked for
    always @(posedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request; valid stays high after the handshake so back-to-back requests need no gap
    task automatic push_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop offering requests and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        // one result per request, so a short settle is enough before touching registers
        repeat (8) @(posedge aclk);
    endtask

    // setup cycle, then access cycle; pready is honored even though it is tied high
    task automatic apb_access(input logic wr, input logic [2:0] idx,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // write every register, then read them all back (the checker compares the reads)
    task automatic program_filter(input filter_setting_t cfg);
        apb_access(1'b1, REG_B0,     cfg.b0);
        apb_access(1'b1, REG_B1,     cfg.b1);
        apb_access(1'b1, REG_B2,     cfg.b2);
        apb_access(1'b1, REG_A1,     cfg.a1);
        apb_access(1'b1, REG_A2,     cfg.a2);
        apb_access(1'b1, REG_GAIN_I, APB_DATA_W'(cfg.gin));
        apb_access(1'b1, REG_GAIN_O, APB_DATA_W'(cfg.gout));
        apb_access(1'b1, REG_BYPASS, APB_DATA_W'(cfg.byp));
        for (int i = REG_B0; i <= REG_BYPASS; i++)
            apb_access(1'b0, 3'(i), '0);
    endtask

    // gains mostly near unity, sometimes zero, full scale or anything
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(32'h2_0000, 32'h8000));
        endcase
    endfunction

    function automatic filter_setting_t pick_setting(input setting_kind_t kind);
        filter_setting_t   cfg;
        logic [COEF_W-1:0] coef [5];
        for (int k = 0; k < 5; k++) begin
            case (kind)
                // +-1.0, with a1 allowed +-2.0 as in ordinary biquads
                SET_MILD: coef[k] = (k == 3) ? $urandom_range(32'h4000_0000) - 32'h2000_0000
                                             : $urandom_range(32'h2000_0000) - 32'h1000_0000;
                SET_WILD: coef[k] = $urandom;
                default: begin
                    case ($urandom_range(2))
                        0:       coef[k] = 32'h8000_0000;
                        1:       coef[k] = 32'h7FFF_FFFF;
                        default: coef[k] = '0;
                    endcase
                end
            endcase
        end
        cfg.b0   = coef[0];
        cfg.b1   = coef[1];
        cfg.b2   = coef[2];
        cfg.a1   = coef[3];
        cfg.a2   = coef[4];
        cfg.gin  = pick_gain();
        cfg.gout = pick_gain();
        cfg.byp  = ($urandom_range(4) == 0);
        return cfg;
    endfunction

    // mix of full-range noise, quiet signal and rail values
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:          return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
            1, 2, 3, 4: return SAMPLE_W'($urandom);
            default:    return SAMPLE_W'($urandom_range(8191)) - 24'd4096;
        endcase
    endfunction

    initial begin
        filter_setting_t     cfg;
        setting_kind_t       kind;
        logic [SAMPLE_W-1:0] rails [8];
        rails = '{24'h7F_FFFF, 24'h80_0000, 24'h00_0000, 24'hFF_FFFF,
                  24'h00_0001, 24'h55_5555, 24'hAA_AAAA, 24'h40_0000};

        // synchronous reset
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first idling mode: sender idles 36%, receiver 79%
        send_idle_pct <= 36;
        recv_idle_pct <= 79;

        // reset settings are a unity filter: rail and bit-pattern samples on every channel
        for (int i = 0; i < 8; i++)
            push_sample(CHAN_W'(i), rails[i]);
        drain_results();

        // every coefficient and gain at its extreme, y and the output saturate
        cfg = '{b0: 32'h7FFF_FFFF, b1: 32'h8000_0000, b2: 32'h7FFF_FFFF,
                a1: 32'h8000_0000, a2: 32'h7FFF_FFFF, gin: '1, gout: '1, byp: 1'b0};
        program_filter(cfg);
        for (int i = 0; i < 6; i++)
            push_sample(CHAN_W'(i / 3), rails[i % 2]);
        drain_results();

        // bypass with both gains at zero: raw samples out, state still runs
        cfg = pick_setting(SET_MILD);
        cfg.gin  = '0;
        cfg.gout = '0;
        cfg.byp  = 1'b1;
        program_filter(cfg);
        for (int i = 0; i < 4; i++)
            push_sample(3'd3, rails[i]);
        drain_results();

        // unity filter with full output gain: small inputs come out scaled up, full scale saturates
        cfg = '{b0: 32'h1000_0000, b1: '0, b2: '0, a1: '0, a2: '0,
                gin: GAIN_W'(32'h1_0000), gout: '1, byp: 1'b0};
        program_filter(cfg);
        push_sample(3'd4, 24'h00_0001);
        push_sample(3'd4, 24'hFF_FFFF);
        push_sample(3'd5, 24'h00_0100);
        push_sample(3'd5, 24'h80_0000);
        drain_results();

        // random part: a new setting per phase, idling modes rotate every four phases
        for (int p = 0; p < PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct <= 79;
                recv_idle_pct <= 36;
            end else if (p == 8) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            kind = (p % 3 != 2) ? SET_MILD : ((p % 2 != 0) ? SET_EXTREME : SET_WILD);
            program_filter(pick_setting(kind));

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // receiver holds off while the sender keeps offering, so s_tready must drop
                if ((p == 5 || p == 9) && n == 20)
                    hold_asks <= hold_asks + 1;
                // runs on one channel are common, so the delay words build up
                if ($urandom_range(1) != 0)
                    last_chan = CHAN_W'($urandom);
                push_sample(last_chan, pick_sample());
            end
            drain_results();
        end

        // everything is back; give the block a little more time to show a stray result
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hdl/bqg_pkg.sv
hdl/bqg_mul.sv
hdl/bqg_dly_mem.sv
hdl/biquad_df2t_gain_bypass.sv
verif/biquad_result_checker.sv
verif/biquad_df2t_gain_bypass_tb.sv
